// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the profiler RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define NRTP_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define NRTP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NRTP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/nrtp_pkg.sv =====
// Shared types and constants of the nested region time profiler.
// No dependencies; used by the top level and the testbench.
package nrtp_pkg;

    localparam int ANCHOR_COUNT_DEF = 4096;
    localparam int STACK_DEPTH_DEF  = 64;
    localparam int ANCHOR_IN_W      = 12;
    localparam int DATA_W           = 64;

    typedef enum logic [1:0] {
        MODE_ENTER = 2'd0,
        MODE_LEAVE = 2'd1,
        MODE_READ  = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    // One anchor record as held in the anchor RAM.
    typedef struct packed {
        logic [DATA_W-1:0] excl;
        logic [DATA_W-1:0] incl;
        logic [DATA_W-1:0] hits;
    } anc_entry_t;

endpackage

// ===== rtl/core/nested_region_time_profiler.sv =====
// Nested region time profiler, top level; uses nrtp_pkg, nrtp_ram and assert_macros.svh.
// Command path: a read passes EXEC and RESP; an enter EXEC, EN_WAIT and RESP; a leave EXEC,
// LV_STK, LV_PAR, LV_ANC_RD, LV_EX, LV_IN, LV_HIT and RESP; a clear EXEC, CLEAR and RESP; FOLD
// and FOLD_SUB come first when the anchor index is at or above ANCHOR_COUNT. One command at a
// time, set by the sequencer around one shared 64-bit adder; in_ready rises as the result is
// registered. Reset clears control at once; a pass then zeroes the anchor RAM, in_ready low.
`include "assert_macros.svh"

module nested_region_time_profiler #(
    parameter int ANCHOR_COUNT = nrtp_pkg::ANCHOR_COUNT_DEF,
    parameter int STACK_DEPTH  = nrtp_pkg::STACK_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     mode,
    input  logic [nrtp_pkg::ANCHOR_IN_W-1:0] anchor,
    input  logic [nrtp_pkg::DATA_W-1:0]    timestamp,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [nrtp_pkg::DATA_W-1:0]    exclusive_total,
    output logic [nrtp_pkg::DATA_W-1:0]    inclusive_total,
    output logic [nrtp_pkg::DATA_W-1:0]    hit_total,
    output logic [1:0]                     status
);

    localparam int DW    = nrtp_pkg::DATA_W;
    localparam int IW    = nrtp_pkg::ANCHOR_IN_W;
    localparam int AW    = (ANCHOR_COUNT > 1) ? $clog2(ANCHOR_COUNT) : 1;
    localparam int SW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LW    = $clog2(STACK_DEPTH + 1);
    // Reciprocal of ANCHOR_COUNT for the anchor field: (index * FOLD_M) >> FOLD_SH is the
    // exact quotient for every index the field can carry.
    localparam int FOLD_SH = IW + AW;
    localparam int FOLD_M  = (2 ** FOLD_SH) / ANCHOR_COUNT + 1;
    localparam int FOLD_PW = 2 * IW + 2;
    // Stack entry layout, low to high: start time, old inclusive, anchor, parent.
    localparam int STK_W = 2 * DW + 2 * AW;
    localparam int ANC_LO = 2 * DW;
    localparam int PAR_LO = 2 * DW + AW;

    // The sequencer. Every command passes through EXEC, which dispatches on the mode,
    // and ends in RESP, which waits for the output register to be free.
    typedef enum logic [13:0] {
        S_IDLE      = 14'b00000000000001,
        S_INIT      = 14'b00000000000010,
        S_CLEAR     = 14'b00000000000100,
        S_FOLD      = 14'b00000000001000,
        S_EXEC      = 14'b00000000010000,
        S_EN_WAIT   = 14'b00000000100000,
        S_LV_STK    = 14'b00000001000000,
        S_LV_PAR    = 14'b00000010000000,
        S_LV_ANC_RD = 14'b00000100000000,
        S_LV_EX     = 14'b00001000000000,
        S_LV_IN     = 14'b00010000000000,
        S_LV_HIT    = 14'b00100000000000,
        S_RESP      = 14'b01000000000000,
        S_FOLD_SUB  = 14'b10000000000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [LW-1:0]          level_reg, level_next;
    logic [AW-1:0]          parent_reg, parent_next;
    logic [AW-1:0]          sweep_reg, sweep_next;
    logic                   out_valid_reg, out_valid_next;

    logic [IW-1:0]          fold_q_reg, fold_q_next;
    logic [IW-1:0]          rem_reg, rem_next;
    nrtp_pkg::mode_t        mode_reg, mode_next;
    logic [DW-1:0]          ts_reg, ts_next;
    logic [DW-1:0]          elapsed_reg, elapsed_next;
    logic [DW-1:0]          acc_ex_reg, acc_ex_next;
    logic [DW-1:0]          acc_in_reg, acc_in_next;
    nrtp_pkg::status_t      res_status_reg, res_status_next;
    logic [DW-1:0]          exclusive_total_reg, exclusive_total_next;
    logic [DW-1:0]          inclusive_total_reg, inclusive_total_next;
    logic [DW-1:0]          hit_total_reg, hit_total_next;
    nrtp_pkg::status_t      status_reg, status_next;

    // Shared adder/subtractor. The top bit is the borrow on a subtraction.
    logic [DW-1:0]          alu_a;
    logic [DW-1:0]          alu_b;
    logic                   alu_sub;
    logic [DW:0]            alu_res;

    // Constant products used to fold an anchor index.
    logic [FOLD_PW-1:0]     fold_prod;
    logic [IW-1:0]          fold_back;

    // Anchor RAM port.
    logic                   anc_we;
    logic [AW-1:0]          anc_waddr;
    nrtp_pkg::anc_entry_t   anc_wdata;
    logic                   anc_re;
    logic [AW-1:0]          anc_raddr;
    nrtp_pkg::anc_entry_t   anc_rdata;

    // Stack RAM port.
    logic                   stk_we;
    logic [SW-1:0]          stk_waddr;
    logic [STK_W-1:0]       stk_wdata;
    logic                   stk_re;
    logic [SW-1:0]          stk_raddr;
    logic [STK_W-1:0]       stk_rdata;

    logic [AW-1:0]          idx;
    logic [AW-1:0]          pop_parent;
    logic [AW-1:0]          pop_anchor;
    logic [DW-1:0]          pop_old_incl;
    logic [DW-1:0]          pop_start;
    logic [LW-1:0]          level_dec;
    logic                   out_free;

    assign alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                             : ({1'b0, alu_a} + {1'b0, alu_b});

    // Quotient times ANCHOR_COUNT never exceeds the index, so the product fits the field.
    assign fold_prod = FOLD_PW'(rem_reg) * FOLD_PW'(FOLD_M);
    assign fold_back = fold_q_reg * IW'(ANCHOR_COUNT);

    // After folding the remainder is below ANCHOR_COUNT, so the cast only drops zeros
    // or adds them.
    assign idx          = AW'(rem_reg);
    assign pop_start    = stk_rdata[DW-1:0];
    assign pop_old_incl = stk_rdata[2*DW-1:DW];
    assign pop_anchor   = stk_rdata[ANC_LO+AW-1:ANC_LO];
    assign pop_parent   = stk_rdata[PAR_LO+AW-1:PAR_LO];
    assign level_dec    = level_reg - LW'(1);
    assign out_free     = !out_valid_reg || out_ready;

    assign in_ready        = (state_reg == S_IDLE);
    assign out_valid       = out_valid_reg;
    assign exclusive_total = exclusive_total_reg;
    assign inclusive_total = inclusive_total_reg;
    assign hit_total       = hit_total_reg;
    assign status          = status_reg;

    always_comb
    begin
        state_next           = state_reg;
        level_next           = level_reg;
        parent_next          = parent_reg;
        sweep_next           = sweep_reg;
        out_valid_next       = out_valid_reg;
        fold_q_next          = fold_q_reg;
        rem_next             = rem_reg;
        mode_next            = mode_reg;
        ts_next              = ts_reg;
        elapsed_next         = elapsed_reg;
        acc_ex_next          = acc_ex_reg;
        acc_in_next          = acc_in_reg;
        res_status_next      = res_status_reg;
        exclusive_total_next = exclusive_total_reg;
        inclusive_total_next = inclusive_total_reg;
        hit_total_next       = hit_total_reg;
        status_next          = status_reg;

        alu_a     = '0;
        alu_b     = '0;
        alu_sub   = 1'b0;
        anc_we    = 1'b0;
        anc_waddr = '0;
        anc_wdata = '0;
        anc_re    = 1'b0;
        anc_raddr = '0;
        stk_we    = 1'b0;
        stk_waddr = level_reg[SW-1:0];
        stk_wdata = {parent_reg, idx, anc_rdata.incl, ts_reg};
        stk_re    = 1'b0;
        stk_raddr = level_dec[SW-1:0];

        // The downstream side drains the output register independently of the sequencer.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next   = nrtp_pkg::mode_t'(mode);
                    rem_next    = anchor;
                    ts_next     = timestamp;
                    // Anchor indexes past the store wrap around; fold them first.
                    if (32'(anchor) >= 32'(ANCHOR_COUNT))
                    begin
                        state_next = S_FOLD;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end

            // Both sweeps write one zero record a cycle. The power-up pass returns to
            // idle silently, the clear command answers with a result beat.
            S_INIT, S_CLEAR:
            begin
                anc_we      = 1'b1;
                anc_waddr   = sweep_reg;
                parent_next = '0;
                if (sweep_reg == AW'(ANCHOR_COUNT - 1))
                begin
                    sweep_next = '0;
                    state_next = (state_reg == S_INIT) ? S_IDLE : S_RESP;
                end
                else
                begin
                    sweep_next = sweep_reg + AW'(1);
                end
            end

            // The quotient by ANCHOR_COUNT comes from one multiply by the reciprocal.
            S_FOLD:
            begin
                fold_q_next = IW'(fold_prod >> FOLD_SH);
                state_next  = S_FOLD_SUB;
            end

            // The remainder is the index less quotient times ANCHOR_COUNT.
            S_FOLD_SUB:
            begin
                alu_a      = DW'(rem_reg);
                alu_b      = DW'(fold_back);
                alu_sub    = 1'b1;
                rem_next   = alu_res[IW-1:0];
                state_next = S_EXEC;
            end

            S_EXEC:
            begin
                res_status_next = nrtp_pkg::ST_OK;
                unique case (mode_reg)
                    nrtp_pkg::MODE_ENTER:
                    begin
                        if (level_reg == LW'(STACK_DEPTH))
                        begin
                            res_status_next = nrtp_pkg::ST_OVERFLOW;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            // Fetch the anchor's inclusive total to save with the frame.
                            anc_re     = 1'b1;
                            anc_raddr  = idx;
                            state_next = S_EN_WAIT;
                        end
                    end
                    nrtp_pkg::MODE_LEAVE:
                    begin
                        if (level_reg == '0)
                        begin
                            res_status_next = nrtp_pkg::ST_UNDERFLOW;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            stk_re     = 1'b1;
                            state_next = S_LV_STK;
                        end
                    end
                    nrtp_pkg::MODE_READ:
                    begin
                        // The read data is held in the RAM output until RESP takes it.
                        anc_re     = 1'b1;
                        anc_raddr  = idx;
                        state_next = S_RESP;
                    end
                    nrtp_pkg::MODE_CLEAR:
                    begin
                        state_next = S_CLEAR;
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end

            S_EN_WAIT:
            begin
                stk_we      = 1'b1;
                level_next  = level_reg + LW'(1);
                parent_next = idx;
                state_next  = S_RESP;
            end

            // The popped frame is on the stack RAM output from here on.
            S_LV_STK:
            begin
                alu_a        = ts_reg;
                alu_b        = pop_start;
                alu_sub      = 1'b1;
                elapsed_next = alu_res[DW-1:0];
                anc_re       = 1'b1;
                anc_raddr    = pop_parent;
                level_next   = level_dec;
                parent_next  = pop_parent;
                state_next   = S_LV_PAR;
            end

            // The parent loses the child's time from its exclusive total. This write
            // lands before the anchor is read, so a region nested in itself nets out.
            S_LV_PAR:
            begin
                alu_a          = anc_rdata.excl;
                alu_b          = elapsed_reg;
                alu_sub        = 1'b1;
                anc_we         = 1'b1;
                anc_waddr      = pop_parent;
                anc_wdata      = anc_rdata;
                anc_wdata.excl = alu_res[DW-1:0];
                state_next     = S_LV_ANC_RD;
            end

            S_LV_ANC_RD:
            begin
                anc_re     = 1'b1;
                anc_raddr  = pop_anchor;
                state_next = S_LV_EX;
            end

            S_LV_EX:
            begin
                alu_a       = anc_rdata.excl;
                alu_b       = elapsed_reg;
                acc_ex_next = alu_res[DW-1:0];
                state_next  = S_LV_IN;
            end

            // Inclusive time restarts from the total saved at entry, which keeps
            // recursive entries of one anchor from being counted twice.
            S_LV_IN:
            begin
                alu_a       = pop_old_incl;
                alu_b       = elapsed_reg;
                acc_in_next = alu_res[DW-1:0];
                state_next  = S_LV_HIT;
            end

            S_LV_HIT:
            begin
                alu_a          = anc_rdata.hits;
                alu_b          = DW'(1);
                anc_we         = 1'b1;
                anc_waddr      = pop_anchor;
                anc_wdata.excl = acc_ex_reg;
                anc_wdata.incl = acc_in_reg;
                anc_wdata.hits = alu_res[DW-1:0];
                state_next     = S_RESP;
            end

            // Commands other than read report zero totals.
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    if (mode_reg == nrtp_pkg::MODE_READ)
                    begin
                        exclusive_total_next = anc_rdata.excl;
                        inclusive_total_next = anc_rdata.incl;
                        hit_total_next       = anc_rdata.hits;
                    end
                    else
                    begin
                        exclusive_total_next = '0;
                        inclusive_total_next = '0;
                        hit_total_next       = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            level_reg     <= '0;
            parent_reg    <= '0;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            parent_reg    <= parent_next;
            sweep_reg     <= sweep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fold_q_reg          <= fold_q_next;
        rem_reg             <= rem_next;
        mode_reg            <= mode_next;
        ts_reg              <= ts_next;
        elapsed_reg         <= elapsed_next;
        acc_ex_reg          <= acc_ex_next;
        acc_in_reg          <= acc_in_next;
        res_status_reg      <= res_status_next;
        exclusive_total_reg <= exclusive_total_next;
        inclusive_total_reg <= inclusive_total_next;
        hit_total_reg       <= hit_total_next;
        status_reg          <= status_next;
    end

    // Per-anchor totals: one record of exclusive, inclusive and hit counts.
    nrtp_ram #(
        .WIDTH ($bits(nrtp_pkg::anc_entry_t)),
        .DEPTH (ANCHOR_COUNT)
    ) u_anchor_ram (
        .clk   (clk),
        .we    (anc_we),
        .waddr (anc_waddr),
        .wdata (anc_wdata),
        .re    (anc_re),
        .raddr (anc_raddr),
        .rdata (anc_rdata)
    );

    // Region stack: one frame per open region.
    nrtp_ram #(
        .WIDTH (STK_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // A sweep must keep new commands out while it writes the anchor RAM.
    `NRTP_ASSERT_IMPL(a_sweep_blocks,
        (state_reg == S_INIT) || (state_reg == S_CLEAR), !in_ready && anc_we,
        "sweep active while input is open or RAM idle")
    // A push always finds room and grows the stack by one frame.
    `NRTP_ASSERT_NEXT(a_push_grows,
        stk_we, level_reg == $past(level_reg) + LW'(1),
        "stack push did not advance the level")
    // The anchor RAM is never read and written in the same cycle, which would break self-nesting.
    `NRTP_ASSERT_ALWAYS(a_no_rw_overlap,
        !(anc_we && anc_re),
        "anchor RAM read and write overlap")
    // A registered result leaves the sequencer idle with a beat on the output.
    `NRTP_ASSERT_NEXT(a_resp_done,
        (state_reg == S_RESP) && out_free, out_valid_reg && in_ready,
        "result not presented after response")

endmodule

// ===== rtl/core/nrtp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; instantiated by the profiler top level.
module nrtp_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read data holds its value until the next read is issued.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== verif/tb_nested_region_time_profiler.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for nested_region_time_profiler, with its own profiler model.
// Depends on nrtp_pkg for the mode and status codes and the table sizes, and on the top level's port list.
module tb_nested_region_time_profiler;
    import nrtp_pkg::*;

    // A run with no accepted beat on either side for this many cycles is hung.
    // It covers the clearing pass after reset, a clear-all walk and the long
    // output hold-off with plenty of margin.
    localparam int QUIET_LIMIT  = 20000;
    localparam int ITEM_TARGET  = 1500;
    localparam int TAIL_CYCLES  = 40;
    localparam int HOLD_CYCLES  = 600;

    // One open region as the profiler keeps it on its stack.
    typedef struct {
        logic [11:0] parent;
        logic [11:0] anc;
        logic [63:0] old_incl;
        logic [63:0] start;
    } frame_t;

    // The result beat one command should produce.
    typedef struct {
        logic [63:0] excl;
        logic [63:0] incl;
        logic [63:0] hits;
        status_t     st;
    } outcome_t;

    // Scoreboard: mirrors the anchor tables and the region stack, turns every
    // accepted command into an expected result beat and checks result beats
    // against them in order.
    class profile_scoreboard;
        logic [63:0] excl_tab [ANCHOR_COUNT_DEF];
        logic [63:0] incl_tab [ANCHOR_COUNT_DEF];
        logic [63:0] hits_tab [ANCHOR_COUNT_DEF];
        logic [11:0] cur_parent;
        frame_t      frames [$];
        outcome_t    awaited [$];
        int          error_count;
        int          results_seen;

        function new();
            error_count  = 0;
            results_seen = 0;
            wipe_anchors();
        endfunction

        function void wipe_anchors();
            foreach (excl_tab[i])
            begin
                excl_tab[i] = '0;
                incl_tab[i] = '0;
                hits_tab[i] = '0;
            end
            cur_parent = '0;
        endfunction

        function int open_depth();
            return frames.size();
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Applies one accepted command and queues the result it must produce.
        function status_t note_command(mode_t m, logic [11:0] a, logic [63:0] ts);
            outcome_t    res;
            frame_t      top;
            logic [11:0] idx;
            logic [63:0] span;
            res.excl = '0;
            res.incl = '0;
            res.hits = '0;
            res.st   = ST_OK;
            idx = 12'(a % ANCHOR_COUNT_DEF);
            case (m)
                MODE_ENTER:
                begin
                    if (frames.size() >= STACK_DEPTH_DEF)
                        res.st = ST_OVERFLOW;
                    else
                    begin
                        top.parent   = cur_parent;
                        top.anc      = idx;
                        top.old_incl = incl_tab[idx];
                        top.start    = ts;
                        frames.push_back(top);
                        cur_parent = idx;
                    end
                end
                MODE_LEAVE:
                begin
                    if (frames.size() == 0)
                        res.st = ST_UNDERFLOW;
                    else
                    begin
                        top  = frames.pop_back();
                        span = ts - top.start;
                        cur_parent = top.parent;
                        excl_tab[top.parent] -= span;
                        excl_tab[top.anc]    += span;
                        incl_tab[top.anc]     = top.old_incl + span;
                        hits_tab[top.anc]    += 64'd1;
                    end
                end
                MODE_READ:
                begin
                    res.excl = excl_tab[idx];
                    res.incl = incl_tab[idx];
                    res.hits = hits_tab[idx];
                end
                default:
                    wipe_anchors();
            endcase
            awaited.push_back(res);
            return res.st;
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $error("%s: expected %h, actual %h", field, want, got);
                error_count++;
            end
        endfunction

        function void check_result(logic [63:0] ex, logic [63:0] inc, logic [63:0] hits,
                                   logic [1:0] st);
            outcome_t want;
            results_seen++;
            if (awaited.size() == 0)
            begin
                $error("result beat with no command outstanding");
                error_count++;
                return;
            end
            want = awaited.pop_front();
            compare_field("exclusive_total", want.excl, ex);
            compare_field("inclusive_total", want.incl, inc);
            compare_field("hit_total", want.hits, hits);
            compare_field("status", 64'(want.st), 64'(st));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  mode;
    logic [11:0] anchor;
    logic [63:0] timestamp;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] exclusive_total;
    logic [63:0] inclusive_total;
    logic [63:0] hit_total;
    logic [1:0]  status;

    profile_scoreboard sb;

    int          burst_left;   // beats left in the current sender burst
    int          items_done;   // commands that were not flagged as over/underflow
    int          clears_left;  // every clear costs a full anchor walk, so ration them
    int          quiet_cycles;
    logic [63:0] tick;         // free-running time base that the stimulus hands out

    nested_region_time_profiler DUT (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Result side: every accepted result beat is checked at the rising edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(exclusive_total, inclusive_total, hit_total, status);
    end

    // The watchdog restarts whenever a beat moves on either channel. A hung
    // block, or one that never returns a result, ends the run here.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Receiver: out_ready follows phases of random length. A phase is either
    // always ready, a coin toss per cycle, or a rotating 8-bit pattern. Once,
    // after a few hundred results, it holds off for a long stretch so that the
    // one command in flight backs up and in_ready stays low while the sender
    // keeps offering.
    initial
    begin
        int         style;
        int         phase_len;
        logic [7:0] mask;
        bit         held_off;
        held_off = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held_off && sb.results_seen >= 300)
            begin
                held_off = 1'b1;
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            style     = $urandom_range(0, 2);
            phase_len = $urandom_range(16, 160);
            mask      = 8'($urandom) | 8'h01;
            for (int k = 0; k < phase_len; k++)
            begin
                @(negedge clk);
                case (style)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= mask[k % 8];
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender tasks. Payload changes at the falling edge; acceptance is seen at
    // the rising edge, where the command goes into the scoreboard.
    // ------------------------------------------------------------------

    // Offers one command beat. Beats come in bursts; between bursts valid
    // drops for a random number of cycles.
    task automatic send_command(input mode_t m, input logic [11:0] a, input logic [63:0] ts);
        int idle_gap;
        if (burst_left == 0)
        begin
            idle_gap = $urandom_range(1, 12);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (idle_gap - 1) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        in_valid  <= 1'b1;
        mode      <= m;
        anchor    <= a;
        timestamp <= ts;
        do
            @(posedge clk);
        while (!in_ready);
        if (sb.note_command(m, a, ts) == ST_OK)
            items_done++;
    endtask

    // Stops offering until every outstanding result has come back.
    task automatic drain_wait();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Mostly a handful of hot anchors so that reads see accumulated totals,
    // with the extremes and the full index range mixed in.
    function automatic logic [11:0] pick_anchor();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 12'($urandom_range(0, 15));
        else if (roll < 80)
            return (roll < 75) ? 12'd0 : 12'hFFF;
        return 12'($urandom);
    endfunction

    // Time normally runs forward, but now and then it jumps anywhere or steps
    // back, so elapsed values wrap around 2^64.
    function automatic logic [63:0] next_stamp();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 90)
            tick += 64'($urandom_range(1, 2000));
        else if (roll < 95)
            tick = {$urandom, $urandom};
        else
            tick -= 64'($urandom_range(1, 500));
        return tick;
    endfunction

    // A well-formed stretch of nested regions with reads in between and, rarely,
    // a clear while regions are open.
    task automatic nested_walk();
        int steps;
        int roll;
        steps = $urandom_range(8, 32);
        repeat (steps)
        begin
            roll = $urandom_range(0, 99);
            if (sb.open_depth() == 0 || (roll < 45 && sb.open_depth() < STACK_DEPTH_DEF))
                send_command(MODE_ENTER, pick_anchor(), next_stamp());
            else if (roll < 85)
                send_command(MODE_LEAVE, 12'($urandom), next_stamp());
            else if (roll < 99 || clears_left == 0)
                send_command(MODE_READ, pick_anchor(), {$urandom, $urandom});
            else
            begin
                clears_left--;
                send_command(MODE_CLEAR, 12'($urandom), {$urandom, $urandom});
            end
        end
    endtask

    // Closes every open region, then leaves once more on the empty stack.
    task automatic unwind_all();
        while (sb.open_depth() != 0)
        begin
            if ($urandom_range(0, 5) == 0)
                send_command(MODE_READ, pick_anchor(), {$urandom, $urandom});
            send_command(MODE_LEAVE, 12'($urandom), next_stamp());
        end
        send_command(MODE_LEAVE, 12'($urandom), next_stamp());
    endtask

    // Fills the stack, runs into overflow a few times, then unwinds to underflow.
    task automatic deep_dive();
        int extra;
        extra = $urandom_range(1, 3);
        while (sb.open_depth() < STACK_DEPTH_DEF)
        begin
            send_command(MODE_ENTER, pick_anchor(), next_stamp());
            if ($urandom_range(0, 7) == 0)
                send_command(MODE_READ, pick_anchor(), {$urandom, $urandom});
        end
        repeat (extra) send_command(MODE_ENTER, pick_anchor(), next_stamp());
        unwind_all();
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        int    choice;
        int    count;
        mode_t m;
        sb          = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        mode        = MODE_ENTER;
        anchor      = '0;
        timestamp   = '0;
        out_ready   = 1'b0;
        burst_left  = 0;
        items_done  = 0;
        clears_left = 24;
        tick        = '0;
        quiet_cycles = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. The tables start at zero, both index extremes are read,
        // a leave on the empty stack underflows, the root is entered as a region,
        // elapsed spans lie near both ends of the 64-bit range, a recursive anchor
        // must not count its inner region twice, a clear lands while a region
        // is open and its leave still pops normally, and an elapsed time wraps.
        send_command(MODE_READ, 12'd0, 64'd0);
        send_command(MODE_READ, 12'hFFF, '1);
        send_command(MODE_LEAVE, 12'hFFF, '1);
        send_command(MODE_ENTER, 12'd0, 64'd0);
        send_command(MODE_ENTER, 12'hFFF, 64'h10);
        send_command(MODE_LEAVE, 12'd0, '1);
        send_command(MODE_LEAVE, 12'hFFF, 64'h5);
        send_command(MODE_READ, 12'hFFF, 64'd0);
        send_command(MODE_READ, 12'd0, 64'd0);
        send_command(MODE_ENTER, 12'd5, 64'd100);
        send_command(MODE_ENTER, 12'd5, 64'd200);
        send_command(MODE_LEAVE, 12'd5, 64'd350);
        send_command(MODE_LEAVE, 12'd5, 64'd1000);
        send_command(MODE_READ, 12'd5, 64'd0);
        send_command(MODE_ENTER, 12'd7, 64'd2000);
        send_command(MODE_CLEAR, 12'hFFF, '1);
        send_command(MODE_READ, 12'd7, 64'd0);
        send_command(MODE_LEAVE, 12'd3, 64'd2500);
        send_command(MODE_READ, 12'd7, 64'd0);
        send_command(MODE_READ, 12'd0, 64'd0);
        send_command(MODE_ENTER, 12'd9, 64'hFFFF_FFFF_FFFF_FFF0);
        send_command(MODE_LEAVE, 12'd9, 64'h20);
        send_command(MODE_READ, 12'd9, 64'd0);
        drain_wait();

        // Random part: one full dive through overflow and underflow first, then
        // a mix dominated by well-formed nesting.
        tick = 64'd5000;
        deep_dive();
        while (items_done < ITEM_TARGET)
        begin
            choice = $urandom_range(0, 99);
            if (choice < 60)
                nested_walk();
            else if (choice < 75)
            begin
                count = $urandom_range(1, 6);
                repeat (count) send_command(MODE_READ, pick_anchor(), {$urandom, $urandom});
            end
            else if (choice < 87)
            begin
                // Noise: any mode, any index, any time.
                count = $urandom_range(1, 5);
                repeat (count)
                begin
                    m = mode_t'($urandom_range(0, 3));
                    if (m == MODE_CLEAR && (clears_left == 0 || $urandom_range(0, 3) != 0))
                        m = MODE_READ;
                    else if (m == MODE_CLEAR)
                        clears_left--;
                    send_command(m, 12'($urandom), {$urandom, $urandom});
                end
            end
            else if (choice < 97)
            begin
                unwind_all();
                if ($urandom_range(0, 3) == 0)
                    drain_wait();
            end
            else
                deep_dive();
        end

        // Let everything outstanding come back, then watch a little longer for
        // stray result beats.
        drain_wait();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/nrtp_pkg.sv
rtl/core/nrtp_ram.sv
rtl/core/nested_region_time_profiler.sv
verif/tb_nested_region_time_profiler.sv
